// File: sv/kto_pkg.sv
// Shared types, widths and codes for the keyed table with oldest-entry replacement.
`default_nettype none

package kto_pkg;

  // Default number of table entries.
  localparam int ENTRIES_DEF = 32;

  // Field widths.
  localparam int KEY_W     = 48;
  localparam int VALUE_W   = 64;
  localparam int TIME_W    = 32;
  localparam int OUTCOME_W = 3;
  localparam int SLOT_W    = 5;

  // Packed stream widths, padded to whole bytes.
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 104;

  // Item kinds carried on the input tuser.
  typedef enum logic {
    ACT_APPLY = 1'b0,
    ACT_FIND  = 1'b1
  } kto_action_t;

  // Result kinds carried on the output tuser.
  typedef enum logic [OUTCOME_W-1:0] {
    OUT_UNCHANGED = 3'd0,
    OUT_CHANGED   = 3'd1,
    OUT_NEW       = 3'd2,
    OUT_FOUND     = 3'd3,
    OUT_MISSING   = 3'd4
  } kto_outcome_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_DONE
  } kto_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // capture the input transfer and restart the scan
    logic scan;      // step the scan over the stores
    logic commit;    // write the stores and latch the result
    logic load_out;  // move the result into the output register
  } kto_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // every entry in use has been read and compared
  } kto_stat_t;

endpackage

`default_nettype wire

// File: sv/keyed_table_oldest_eviction_core.sv
// Top level of the keyed table with oldest-entry replacement.
//
// A fully associative table of up to ENTRIES entries, each holding a 48-bit key, a 64-bit
// value and a 32-bit first-seen time, starting empty after reset. An apply item updates
// the value of a matching key, or appends a new entry, replacing the entry with the
// smallest first-seen time (lowest index on a tie) once the table is full; a find item
// reports the matching entry. Items are handled one at a time, each by a linear scan that
// reads the key, value and time stores through their shared address, one entry per
// cycle. The next input transfer is taken while a finished result still waits in the
// output register.
`default_nettype none

module keyed_table_oldest_eviction_core #(
  parameter int ENTRIES = kto_pkg::ENTRIES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Input stream.
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // From bit 0: entry_key[47:0], entry_value[111:48], now_ms[143:112].
  input  wire logic [kto_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // From bit 0: action.
  input  wire logic                            s_axis_tuser,
  // Result stream.
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // From bit 0: slot[4:0], evicted[5], found_value[69:6], first_seen[101:70], zero pad.
  output      logic [kto_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // From bit 0: outcome[2:0].
  output      logic [kto_pkg::OUTCOME_W-1:0]   m_axis_tuser
);

  kto_pkg::kto_cmd_t  cmd;
  kto_pkg::kto_stat_t stat;

  kto_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  kto_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cmd          (cmd),
    .stat         (stat),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

`default_nettype wire

// File: sv/kto_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module kto_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                       wdata,
  output      logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: an optional write, and a read of the old contents into the output register.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: sv/kto_dp.sv
// Datapath: entry stores, linear key and oldest-time scan, write-back and result registers.
`default_nettype none

module kto_dp #(
  parameter int ENTRIES = kto_pkg::ENTRIES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [kto_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  wire logic                               s_axis_tuser,
  input  wire kto_pkg::kto_cmd_t                  cmd,
  output      kto_pkg::kto_stat_t                 stat,
  output      logic [kto_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output      logic [kto_pkg::OUTCOME_W-1:0]      m_axis_tuser
);

  localparam int AddrW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CntW   = $clog2(ENTRIES + 1);
  localparam int KeyW   = kto_pkg::KEY_W;
  localparam int ValW   = kto_pkg::VALUE_W;
  localparam int TimeW  = kto_pkg::TIME_W;
  localparam int SlotW  = kto_pkg::SLOT_W;
  localparam int PadW   = kto_pkg::OUT_DATA_W - SlotW - 1 - ValW - TimeW;

  // Captured input item.
  kto_pkg::kto_action_t action;
  logic [KeyW-1:0]      in_key;
  logic [ValW-1:0]      in_value;
  logic [TimeW-1:0]     in_now;

  // Scan state.
  logic [CntW-1:0]  idx;
  logic [CntW-1:0]  count;
  logic             rd_vld;
  logic [AddrW-1:0] rd_idx;
  logic             hit_found;
  logic [AddrW-1:0] hit_idx;
  logic [ValW-1:0]  hit_val;
  logic [TimeW-1:0] hit_time;
  logic [AddrW-1:0] best_idx;
  logic [TimeW-1:0] best_time;

  // Result waiting for the output register.
  kto_pkg::kto_outcome_t res_outcome;
  logic [SlotW-1:0]      res_slot;
  logic                  res_evicted;
  logic [ValW-1:0]       res_value;
  logic [TimeW-1:0]      res_time;

  // Output register.
  kto_pkg::kto_outcome_t out_outcome;
  logic [SlotW-1:0]      out_slot;
  logic                  out_evicted;
  logic [ValW-1:0]       out_value;
  logic [TimeW-1:0]      out_time;

  // Store ports.
  logic [AddrW-1:0] ram_addr;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] miss_addr;
  logic             key_we;
  logic             value_we;
  logic [KeyW-1:0]  key_rd;
  logic [ValW-1:0]  value_rd;
  logic [TimeW-1:0] time_rd;

  // Decision for the commit cycle.
  kto_pkg::kto_outcome_t dec_outcome;
  logic [AddrW-1:0]      dec_idx;
  logic                  dec_evicted;
  logic [ValW-1:0]       dec_value;
  logic [TimeW-1:0]      dec_time;
  logic                  full;
  logic                  key_match;

  assign full      = (count == CntW'(ENTRIES));
  assign miss_addr = full ? best_idx : count[AddrW-1:0];
  assign wr_addr   = hit_found ? hit_idx : miss_addr;
  assign ram_addr  = cmd.commit ? wr_addr : idx[AddrW-1:0];
  assign key_match = rd_vld && (key_rd == in_key);

  assign stat.scan_done = (idx == count) && !rd_vld;

  // The three stores share one address: read during the scan, written on commit.
  kto_ram #(.WIDTH(KeyW), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .addr  (ram_addr),
    .wdata (in_key),
    .rdata (key_rd)
  );

  kto_ram #(.WIDTH(ValW), .DEPTH(ENTRIES)) u_value_ram (
    .clk   (clk),
    .we    (value_we),
    .addr  (ram_addr),
    .wdata (in_value),
    .rdata (value_rd)
  );

  kto_ram #(.WIDTH(TimeW), .DEPTH(ENTRIES)) u_time_ram (
    .clk   (clk),
    .we    (key_we),
    .addr  (ram_addr),
    .wdata (in_now),
    .rdata (time_rd)
  );

  // Decide the outcome and which stores to write from the scan results.
  always_comb begin
    dec_outcome = kto_pkg::OUT_MISSING;
    dec_idx     = '0;
    dec_evicted = 1'b0;
    dec_value   = '0;
    dec_time    = '0;
    key_we      = 1'b0;
    value_we    = 1'b0;
    if (action == kto_pkg::ACT_FIND) begin
      if (hit_found) begin
        dec_outcome = kto_pkg::OUT_FOUND;
        dec_idx     = hit_idx;
        dec_value   = hit_val;
        dec_time    = hit_time;
      end
    end else if (hit_found) begin
      dec_idx = hit_idx;
      if (hit_val == in_value) begin
        dec_outcome = kto_pkg::OUT_UNCHANGED;
      end else begin
        dec_outcome = kto_pkg::OUT_CHANGED;
        value_we    = cmd.commit;
      end
    end else begin
      dec_outcome = kto_pkg::OUT_NEW;
      dec_idx     = miss_addr;
      dec_evicted = full;
      key_we      = cmd.commit;
      value_we    = cmd.commit;
    end
  end

  // Input capture and scan control.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld    <= 1'b0;
      hit_found <= 1'b0;
      idx       <= '0;
    end else if (cmd.load_in) begin
      action    <= kto_pkg::kto_action_t'(s_axis_tuser);
      in_key    <= s_axis_tdata[KeyW-1:0];
      in_value  <= s_axis_tdata[KeyW+ValW-1:KeyW];
      in_now    <= s_axis_tdata[KeyW+ValW+TimeW-1:KeyW+ValW];
      idx       <= '0;
      rd_vld    <= 1'b0;
      hit_found <= 1'b0;
    end else if (cmd.scan) begin
      if (idx != count) begin
        idx    <= idx + CntW'(1);
        rd_vld <= 1'b1;
        rd_idx <= idx[AddrW-1:0];
      end else begin
        rd_vld <= 1'b0;
      end
      // The first matching key wins.
      if (key_match && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
        hit_val   <= value_rd;
        hit_time  <= time_rd;
      end
    end
  end

  // Oldest entry so far; a strict compare keeps the lowest index on a tie.
  always_ff @(posedge clk) begin
    if (rd_vld && ((rd_idx == '0) || (time_rd < best_time))) begin
      best_idx  <= rd_idx;
      best_time <= time_rd;
    end
  end

  // Entry count: grows on an append, holds once the table is full.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit && key_we && !full) begin
      count <= count + CntW'(1);
    end
  end

  // Result and output registers.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_outcome <= dec_outcome;
      res_slot    <= SlotW'(dec_idx);
      res_evicted <= dec_evicted;
      res_value   <= dec_value;
      res_time    <= dec_time;
    end
    if (cmd.load_out) begin
      out_outcome <= res_outcome;
      out_slot    <= res_slot;
      out_evicted <= res_evicted;
      out_value   <= res_value;
      out_time    <= res_time;
    end
  end

  assign m_axis_tdata = {{PadW{1'b0}}, out_time, out_value, out_evicted, out_slot};
  assign m_axis_tuser = out_outcome;

  // The entry count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(ENTRIES))
    else $error("entry count beyond table size");

  // A read in flight always belongs to an entry in use.
  a_read_in_use: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> (CntW'(rd_idx) < count))
    else $error("scan read past the entries in use");

  // An append into a table with room adds exactly one entry.
  a_append_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && key_we && !full) |=> (count == $past(count) + CntW'(1)))
    else $error("append did not grow the entry count");

endmodule

`default_nettype wire

// File: sv/kto_ctrl.sv
// Controller: sequences capture, scan, commit and output hand-off for one item at a time.
`default_nettype none

module kto_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  input  wire kto_pkg::kto_stat_t  stat,
  output      kto_pkg::kto_cmd_t   cmd
);

  kto_pkg::kto_state_t state;
  kto_pkg::kto_state_t state_next;
  logic                out_valid;
  logic                out_valid_next;
  logic                out_free;

  // The output register can take a result when empty or being drained.
  assign out_free = !out_valid || m_axis_tready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      kto_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = kto_pkg::ST_SCAN;
        end
      end
      kto_pkg::ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = kto_pkg::ST_COMMIT;
        end
      end
      kto_pkg::ST_COMMIT: begin
        state_next = kto_pkg::ST_DONE;
      end
      kto_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = kto_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kto_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands and input ready; no transfer is taken while reset is held.
  always_comb begin
    cmd           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      kto_pkg::ST_IDLE: begin
        s_axis_tready = !rst;
        cmd.load_in   = s_axis_tvalid && !rst;
      end
      kto_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      kto_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
      end
      kto_pkg::ST_DONE: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Output valid: set when a result is loaded, cleared when its transfer completes.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kto_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign m_axis_tvalid = out_valid;

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || m_axis_tready))
    else $error("result loaded over a pending output");

endmodule

`default_nettype wire
